/* hdl/swarq_pkg.sv */
// shared types, command and register codes for the stop-and-wait link endpoint
// no dependencies; used by every module under hdl
package swarq_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int CMD_W  = 2;
  localparam int WORD_W = 32;
  localparam int TRY_W  = 9;
  localparam int RETX_W = 16;
  localparam int LIMIT_W = 8;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ACK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DATA = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_RETX_INTERVAL = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TRY_LIMIT     = 1'd1;

  localparam logic [RETX_W-1:0]  RETX_INTERVAL_RST = 16'd500;
  localparam logic [LIMIT_W-1:0] TRY_LIMIT_RST     = 8'd5;

  // input tdata: now_time, msg_seq, msg_payload from the lowest bit up
  localparam int IN_DATA_W  = 96;
  // output tdata: accepted, tx_seq, tx_payload, ack_seq, deliver_seq,
  // deliver_payload, in_flight, link_dead, try_count, zero fill
  localparam int OUT_DATA_W = 176;
  localparam int OUT_USER_W = 2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] now_time;
    logic [WORD_W-1:0] msg_seq;
    logic [WORD_W-1:0] msg_payload;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic              tx_valid;
    logic [WORD_W-1:0] tx_seq;
    logic [WORD_W-1:0] tx_payload;
    logic              ack_valid;
    logic [WORD_W-1:0] ack_seq;
    logic [WORD_W-1:0] deliver_seq;
    logic [WORD_W-1:0] deliver_payload;
    logic              in_flight;
    logic              link_dead;
    logic [TRY_W-1:0]  try_count;
  } result_t;

endpackage

/* hdl/swarq_ram.sv */
// payload queue memory: one write port, one registered read port
// same-cycle write to the address being read is forwarded; uses swarq_pkg
module swarq_ram #(
  parameter int QUEUE_DEPTH = swarq_pkg::QUEUE_DEPTH_DEF,
  parameter int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_addr,
  input  logic [swarq_pkg::WORD_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [IDX_W-1:0]          rd_addr,
  output logic [swarq_pkg::WORD_W-1:0] rd_data
);
  import swarq_pkg::*;

  logic [WORD_W-1:0] mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      // bypass so a send into an empty queue is seen by the next item
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

/* hdl/swarq_engine.sv */
// link state, configuration registers and the per-word update
// reads the head payload from swarq_ram as each word is accepted, ahead of its commit; uses swarq_pkg
module swarq_engine #(
  parameter int QUEUE_DEPTH = swarq_pkg::QUEUE_DEPTH_DEF,
  parameter int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [swarq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [swarq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            commit,
  input  swarq_pkg::item_t                item,
  input  logic [swarq_pkg::WORD_W-1:0]    head_payload,
  output logic                            wr_en,
  output logic [IDX_W-1:0]                wr_addr,
  output logic [IDX_W-1:0]                rd_addr,
  output swarq_pkg::result_t              result
);
  import swarq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = IDX_W + 2;

  logic [RETX_W-1:0]  retx_interval;
  logic [LIMIT_W-1:0] try_limit;

  logic [IDX_W-1:0]  head_index, head_index_next;
  logic [CNT_W-1:0]  queue_count, queue_count_next;
  logic [WORD_W-1:0] next_send_seq, next_send_seq_next;
  logic [WORD_W-1:0] last_sent_time, last_sent_time_next;
  logic              has_been_sent, has_been_sent_next;
  logic [TRY_W-1:0]  tries, tries_next;
  logic              dead_flag, dead_flag_next;
  logic              peer_seen, peer_seen_next;
  logic [WORD_W-1:0] peer_seq, peer_seq_next;

  logic [WORD_W-1:0] head_seq;
  logic [WORD_W-1:0] elapsed;
  logic [WORD_W-1:0] expect_seq;
  logic [TRY_W-1:0]  tries_inc;
  logic [SUM_W-1:0]  tail_sum;
  logic [IDX_W-1:0]  head_inc;
  logic              send_ok;
  logic              tick_due;

  always_ff @(posedge clk) begin
    if (rst) begin
      retx_interval <= RETX_INTERVAL_RST;
      try_limit     <= TRY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RETX_INTERVAL: retx_interval <= cfg_wdata;
        REG_TRY_LIMIT:     try_limit <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign head_seq   = next_send_seq - WORD_W'(queue_count);
  assign elapsed    = item.now_time - last_sent_time;
  assign expect_seq = peer_seen ? (peer_seq + 32'd1) : '0;
  assign tries_inc  = tries + 9'd1;
  assign tail_sum   = SUM_W'(head_index) + SUM_W'(queue_count);
  assign head_inc   = (head_index == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_index + 1'b1;
  assign send_ok    = !dead_flag && (queue_count != CNT_W'(QUEUE_DEPTH));
  assign tick_due   = (queue_count != '0) && !dead_flag &&
                      !(has_been_sent && (elapsed < WORD_W'(retx_interval)));

  // tail slot: head plus count folded once into the ring
  always_comb begin
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      wr_addr = IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      wr_addr = IDX_W'(tail_sum);
    end
  end

  always_comb begin
    head_index_next     = head_index;
    queue_count_next    = queue_count;
    next_send_seq_next  = next_send_seq;
    last_sent_time_next = last_sent_time;
    has_been_sent_next  = has_been_sent;
    tries_next          = tries;
    dead_flag_next      = dead_flag;
    peer_seen_next      = peer_seen;
    peer_seq_next       = peer_seq;
    result              = '0;
    wr_en               = 1'b0;

    unique case (item.cmd)
      CMD_SEND: begin
        if (send_ok) begin
          wr_en              = commit;
          queue_count_next   = queue_count + 1'b1;
          next_send_seq_next = next_send_seq + 32'd1;
          result.accepted    = 1'b1;
        end
      end
      CMD_TICK: begin
        if (tick_due) begin
          tries_next = tries_inc;
          if (tries_inc > TRY_W'(try_limit)) begin
            dead_flag_next = 1'b1;
          end else begin
            last_sent_time_next = item.now_time;
            has_been_sent_next  = 1'b1;
            result.accepted     = 1'b1;
            result.tx_valid     = 1'b1;
            result.tx_seq       = head_seq;
            result.tx_payload   = head_payload;
          end
        end
      end
      CMD_ACK: begin
        if ((queue_count != '0) && (item.msg_seq == head_seq)) begin
          head_index_next    = head_inc;
          queue_count_next   = queue_count - 1'b1;
          has_been_sent_next = 1'b0;
          tries_next         = '0;
        end
      end
      CMD_DATA: begin
        result.ack_valid = 1'b1;
        result.ack_seq   = item.msg_seq;
        if (item.msg_seq == expect_seq) begin
          peer_seen_next         = 1'b1;
          peer_seq_next          = item.msg_seq;
          result.accepted        = 1'b1;
          result.deliver_seq     = item.msg_seq;
          result.deliver_payload = item.msg_payload;
        end
      end
      default: ;
    endcase

    result.in_flight = (queue_count_next != '0);
    result.link_dead = dead_flag_next;
    result.try_count = tries_next;
  end

  // the next word's head read sees the head this word leaves behind
  assign rd_addr = commit ? head_index_next : head_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index     <= '0;
      queue_count    <= '0;
      next_send_seq  <= '0;
      last_sent_time <= '0;
      has_been_sent  <= 1'b0;
      tries          <= '0;
      dead_flag      <= 1'b0;
      peer_seen      <= 1'b0;
      peer_seq       <= '0;
    end else if (commit) begin
      head_index     <= head_index_next;
      queue_count    <= queue_count_next;
      next_send_seq  <= next_send_seq_next;
      last_sent_time <= last_sent_time_next;
      has_been_sent  <= has_been_sent_next;
      tries          <= tries_next;
      dead_flag      <= dead_flag_next;
      peer_seen      <= peer_seen_next;
      peer_seq       <= peer_seq_next;
    end
  end

endmodule

/* hdl/stop_and_wait_arq_link.sv */
// top level of the stop-and-wait link endpoint: stream ports, item stage,
// output register; uses swarq_pkg, swarq_ram and swarq_engine
//
//  channel   dir  handshake          contents
//  s_*       in   s_tvalid/s_tready  one command word per transfer
//  m_*       out  m_tvalid/m_tready  one result word per command
//  cfg_*     in   cfg_we             retransmit interval, try limit
//
// a word is accepted into the item register, the head payload is read from the
// queue memory in that same edge, and the word commits once the result register
// is free; accept and commit overlap, so one word per cycle is sustained when the
// result side keeps up. the result register loads at the commit edge, which
// raises m_tvalid; the result is held until it is taken.
// rst (synchronous) empties the queue, clears link state and loads register
// defaults; the queue memory itself is not cleared.
// a stalled result register holds the pending word and drops s_tready.
module stop_and_wait_arq_link #(
  parameter int QUEUE_DEPTH = swarq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [swarq_pkg::IN_DATA_W-1:0]    s_tdata,  // now_time, msg_seq, msg_payload
  input  logic [swarq_pkg::CMD_W-1:0]        s_tuser,  // cmd
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // accepted, tx_seq, tx_payload, ack_seq, deliver_seq, deliver_payload,
  // in_flight, link_dead, try_count, zero fill
  output logic [swarq_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [swarq_pkg::OUT_USER_W-1:0]   m_tuser,  // tx_valid, ack_valid
  input  logic                               cfg_we,
  input  logic [swarq_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [swarq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import swarq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic              pend_valid;
  item_t             pend_item;
  logic              commit;
  logic              accept;
  logic [WORD_W-1:0] head_payload;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  result_t           result;

  assign commit   = pend_valid && (!m_tvalid || m_tready);
  assign s_tready = !pend_valid || commit;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (commit) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_item.cmd         <= s_tuser;
      pend_item.now_time    <= s_tdata[31:0];
      pend_item.msg_seq     <= s_tdata[63:32];
      pend_item.msg_payload <= s_tdata[95:64];
    end
  end

  swarq_ram #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .IDX_W      (IDX_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(pend_item.msg_payload),
    .rd_en  (accept),
    .rd_addr(rd_addr),
    .rd_data(head_payload)
  );

  swarq_engine #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .IDX_W      (IDX_W)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .commit      (commit),
    .item        (pend_item),
    .head_payload(head_payload),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {4'd0, result.try_count, result.link_dead, result.in_flight,
                  result.deliver_payload, result.deliver_seq, result.ack_seq,
                  result.tx_payload, result.tx_seq, result.accepted};
      m_tuser <= {result.ack_valid, result.tx_valid};
    end
  end

endmodule

/* bench/stop_and_wait_arq_link_tb.sv */
// self-checking bench for the stop-and-wait link endpoint: directed and random commands,
// a cycle-free predictor of every result word, random stalls on both stream sides
// depends on swarq_pkg and the stop_and_wait_arq_link rtl
module stop_and_wait_arq_link_tb;
  import swarq_pkg::*;

  class arq_link_model;
    bit [RETX_W-1:0]  interval;
    bit [LIMIT_W-1:0] limit;
    bit [WORD_W-1:0]  payloads [QUEUE_DEPTH_DEF];
    bit [2:0]         head;
    bit [3:0]         count;
    bit [WORD_W-1:0]  seq_ctr;
    bit [WORD_W-1:0]  last_tx_time;
    bit               tx_once;
    bit [TRY_W-1:0]   tries;
    bit               dead;
    bit               peer_seen;
    bit [WORD_W-1:0]  last_peer;
    result_t          owed_results[$];
    int               errors;

    function new();
      interval = RETX_INTERVAL_RST;
      limit    = TRY_LIMIT_RST;
      errors   = 0;
    endfunction

    function bit [WORD_W-1:0] head_seq();
      return seq_ctr - WORD_W'(count);
    endfunction

    function bit [WORD_W-1:0] peer_expect();
      return peer_seen ? last_peer + 1 : '0;
    endfunction

    function bit retx_due(bit [WORD_W-1:0] now);
      return count != 0 && !dead &&
             !(tx_once && (now - last_tx_time) < WORD_W'(interval));
    endfunction

    function void take_command(item_t it);
      result_t  r;
      bit [2:0] slot;
      r = '0;
      case (it.cmd)
        CMD_SEND: begin
          if (!dead && count < QUEUE_DEPTH_DEF) begin
            slot = head + count[2:0];
            payloads[slot] = it.msg_payload;
            count++;
            seq_ctr++;
            r.accepted = 1'b1;
          end
        end
        CMD_TICK: begin
          if (retx_due(it.now_time)) begin
            tries++;
            if (tries > TRY_W'(limit)) begin
              dead = 1'b1;
            end else begin
              last_tx_time = it.now_time;
              tx_once      = 1'b1;
              r.accepted   = 1'b1;
              r.tx_valid   = 1'b1;
              r.tx_seq     = head_seq();
              r.tx_payload = payloads[head];
            end
          end
        end
        CMD_ACK: begin
          if (count != 0 && it.msg_seq == head_seq()) begin
            head++;
            count--;
            tx_once = 1'b0;
            tries   = '0;
          end
        end
        CMD_DATA: begin
          r.ack_valid = 1'b1;
          r.ack_seq   = it.msg_seq;
          if (it.msg_seq == peer_expect()) begin
            peer_seen         = 1'b1;
            last_peer         = it.msg_seq;
            r.accepted        = 1'b1;
            r.deliver_seq     = it.msg_seq;
            r.deliver_payload = it.msg_payload;
          end
        end
      endcase
      r.in_flight = count != 0;
      r.link_dead = dead;
      r.try_count = tries;
      owed_results.push_back(r);
    endfunction

    function void cmp(string name, logic [WORD_W-1:0] exp, logic [WORD_W-1:0] got);
      if (got !== exp) begin
        $error("%s: expected %0h, got %0h", name, exp, got);
        errors++;
      end
    endfunction

    function void match_result(logic [OUT_DATA_W-1:0] d, logic [OUT_USER_W-1:0] u);
      result_t w;
      if (owed_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      w = owed_results.pop_front();
      cmp("accepted",        w.accepted,        d[0]);
      cmp("tx_valid",        w.tx_valid,        u[0]);
      cmp("tx_seq",          w.tx_seq,          d[32:1]);
      cmp("tx_payload",      w.tx_payload,      d[64:33]);
      cmp("ack_valid",       w.ack_valid,       u[1]);
      cmp("ack_seq",         w.ack_seq,         d[96:65]);
      cmp("deliver_seq",     w.deliver_seq,     d[128:97]);
      cmp("deliver_payload", w.deliver_payload, d[160:129]);
      cmp("in_flight",       w.in_flight,       d[161]);
      cmp("link_dead",       w.link_dead,       d[162]);
      cmp("try_count",       w.try_count,       d[171:163]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // now_time, msg_seq, msg_payload
  logic [CMD_W-1:0]      s_tuser;   // cmd
  logic                  m_tvalid;
  logic                  m_tready;
  // accepted, tx_seq, tx_payload, ack_seq, deliver_seq, deliver_payload,
  // in_flight, link_dead, try_count, zero fill
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;   // tx_valid, ack_valid
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  arq_link_model   link_model;
  bit              idle_on;
  bit              death_ok;
  bit [WORD_W-1:0] now_ms;

  stop_and_wait_arq_link dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random back-pressure, checked at the rising edge
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = idle_on ? ($urandom_range(99) >= 29) : 1'b1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) link_model.match_result(m_tdata, m_tuser);
    end
  end

  // each idle cycle is drawn on its own, with the same chance each time
  task send_word(item_t it);
    if (idle_on && $urandom_range(99) < 29) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      while ($urandom_range(99) < 29) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = it.cmd;
    s_tdata  = {it.msg_payload, it.msg_seq, it.now_time};
    do @(posedge clk); while (!s_tready);
    link_model.take_command(it);
  endtask

  task send_cmd(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] now, logic [WORD_W-1:0] seq,
                logic [WORD_W-1:0] payload);
    item_t it;
    it.cmd         = cmd;
    it.now_time    = now;
    it.msg_seq     = seq;
    it.msg_payload = payload;
    send_word(it);
  endtask

  // stop sending and let every owed result word drain
  task settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (link_model.owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(logic [CFG_ADDR_W-1:0] addr, int value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    if (addr == REG_RETX_INTERVAL) link_model.interval = RETX_W'(value);
    else link_model.limit = LIMIT_W'(value);
  endtask

  // time mostly hovers around the retransmit interval so due and not-due ticks mix
  function automatic bit [WORD_W-1:0] next_now();
    int pick;
    int ival;
    pick = $urandom_range(99);
    ival = int'(link_model.interval);
    if (pick < 40) now_ms += $urandom_range(3);
    else if (pick < 80) now_ms += WORD_W'(ival - 2 + $urandom_range(4));
    else if (pick < 95) now_ms += $urandom_range(2 * ival);
    else now_ms = $urandom;
    return now_ms;
  endfunction

  function automatic item_t make_item();
    item_t it;
    int    pick;
    int    k;
    it.now_time    = next_now();
    it.msg_seq     = $urandom;
    it.msg_payload = $urandom;
    pick = $urandom_range(99);
    if (pick < 10) begin
      it.cmd = CMD_W'($urandom_range(3));
    end else if (pick < 40) begin
      it.cmd = CMD_SEND;
    end else if (pick < 70) begin
      it.cmd = CMD_TICK;
    end else if (pick < 85) begin
      it.cmd = CMD_ACK;
      k = $urandom_range(9);
      if (k < 8) it.msg_seq = link_model.head_seq();
      else if (k == 8) it.msg_seq = link_model.head_seq() - 1;
    end else begin
      it.cmd = CMD_DATA;
      k = $urandom_range(19);
      if (k < 15) it.msg_seq = link_model.peer_expect();
      else if (k < 18) it.msg_seq = link_model.last_peer;
    end
    // a dead link only clears at reset, so keep it alive until the last phase
    if (it.cmd == CMD_TICK && !death_ok && link_model.tries >= TRY_W'(link_model.limit) &&
        link_model.retx_due(it.now_time)) begin
      it.cmd     = CMD_ACK;
      it.msg_seq = link_model.head_seq();
    end
    return it;
  endfunction

  task run_random(int n);
    repeat (n) send_word(make_item());
  endtask

  initial begin
    link_model = new();
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_SEND;
    cfg_we    = 1'b0;
    cfg_addr  = REG_RETX_INTERVAL;
    cfg_wdata = '0;
    idle_on   = 1'b1;
    death_ok  = 1'b0;
    now_ms    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // receive path: first word, duplicate, out of order, next in order
    send_cmd(CMD_DATA, 32'h0, 32'h0, 32'h0);
    send_cmd(CMD_DATA, 32'h0, 32'h0, 32'h1234_5678);
    send_cmd(CMD_DATA, 32'h0, 32'h5, 32'hdead_beef);
    send_cmd(CMD_DATA, 32'hffff_ffff, 32'h1, 32'hffff_ffff);
    // ack and tick with nothing queued
    send_cmd(CMD_ACK, 32'h0, 32'h0, 32'h0);
    send_cmd(CMD_TICK, 32'h0, 32'h0, 32'h0);
    send_cmd(CMD_SEND, 32'h0, 32'h0, 32'hffff_ffff);
    send_cmd(CMD_SEND, 32'h0, 32'hffff_ffff, 32'h0);
    // first transmit, too early, exactly on the interval
    send_cmd(CMD_TICK, 32'd0, 32'h0, 32'h0);
    send_cmd(CMD_TICK, 32'd499, 32'h0, 32'h0);
    send_cmd(CMD_TICK, 32'd500, 32'h0, 32'h0);
    send_cmd(CMD_ACK, 32'h0, 32'h1, 32'h0);
    send_cmd(CMD_ACK, 32'h0, 32'h0, 32'h0);
    // interval measured across the time wrap
    send_cmd(CMD_TICK, 32'hffff_ffff, 32'h0, 32'h0);
    send_cmd(CMD_TICK, 32'h0000_01f3, 32'h0, 32'h0);
    send_cmd(CMD_ACK, 32'h0, 32'h1, 32'h0);
    // fill the queue, then one more is refused
    repeat (9) send_cmd(CMD_SEND, 32'h0, $urandom, $urandom);

    settle();
    write_reg(REG_RETX_INTERVAL, 1);
    write_reg(REG_TRY_LIMIT, 1);
    run_random(150);

    settle();
    write_reg(REG_RETX_INTERVAL, 65535);
    write_reg(REG_TRY_LIMIT, 255);
    run_random(75);
    settle();
    run_random(75);

    settle();
    write_reg(REG_RETX_INTERVAL, $urandom_range(2, 1000));
    write_reg(REG_TRY_LIMIT, $urandom_range(2, 8));
    idle_on = 1'b0;
    run_random(300);
    idle_on = 1'b1;

    settle();
    write_reg(REG_RETX_INTERVAL, 20);
    write_reg(REG_TRY_LIMIT, 3);
    run_random(200);

    // exhaust the largest try limit, then keep going on a dead link
    settle();
    write_reg(REG_RETX_INTERVAL, 1);
    write_reg(REG_TRY_LIMIT, 255);
    death_ok = 1'b1;
    send_cmd(CMD_SEND, now_ms, $urandom, $urandom);
    repeat (258) begin
      now_ms = now_ms + 1 + $urandom_range(2);
      send_cmd(CMD_TICK, now_ms, $urandom, $urandom);
    end
    run_random(100);

    settle();
    if (link_model.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
